// ===== design/assert_macros.svh =====
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// plain condition checked at every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

`endif

// ===== design/fdf_pkg.sv =====
// types and constants of the frame deframer
package fdf_pkg;

   localparam logic [7:0]  START_BYTE  = 8'h68;
   localparam logic [7:0]  END_BYTE    = 8'h16;
   localparam logic [15:0] FIXED_PLAIN = 16'd15;
   localparam logic [15:0] FIXED_ADDR  = 16'd27;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_CHECKSUM = 2'd1;
   localparam logic [1:0] STAT_END_BYTE = 2'd2;
   localparam logic [1:0] STAT_SHORT    = 2'd3;

   typedef struct packed {
      logic [7:0]  ctrl;
      logic [39:0] info;
      logic [7:0]  seq_num;
      logic [47:0] source;
      logic [47:0] dest;
      logic [7:0]  afn;
      logic [15:0] fn_id;
   } hdr_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] status;
      logic [7:0] data;
      hdr_type    hdr;
   } item_type;

endpackage

// ===== design/fdf_queue.sv =====
// two-entry queue of decoded items between the parser and the output stage
module fdf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  fdf_pkg::item_type push_item,
   output logic              full,
   input  logic              pop_ready,
   output logic              pop_valid,
   output fdf_pkg::item_type pop_item
);

   fdf_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/fdf_front.sv =====
// byte parser: hunts for frames, tracks fields and checksum, classifies bytes into items
module fdf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        rx_byte,
   output logic              push_valid,
   output fdf_pkg::item_type push_item
);

   localparam logic [3:0] PH_HUNT   = 4'd0;
   localparam logic [3:0] PH_LEN_LO = 4'd1;
   localparam logic [3:0] PH_LEN_HI = 4'd2;
   localparam logic [3:0] PH_CTRL   = 4'd3;
   localparam logic [3:0] PH_INFO   = 4'd4;
   localparam logic [3:0] PH_SEQ    = 4'd5;
   localparam logic [3:0] PH_SRC    = 4'd6;
   localparam logic [3:0] PH_DST    = 4'd7;
   localparam logic [3:0] PH_AFN    = 4'd8;
   localparam logic [3:0] PH_FN_LO  = 4'd9;
   localparam logic [3:0] PH_FN_HI  = 4'd10;
   localparam logic [3:0] PH_DATA   = 4'd11;
   localparam logic [3:0] PH_CS     = 4'd12;
   localparam logic [3:0] PH_END    = 4'd13;

   logic [3:0]       phase_ff;
   logic [3:0]       phase_in;
   logic [15:0]      count_ff;
   logic [15:0]      count_in;
   logic [15:0]      length_ff;
   logic [15:0]      length_in;
   logic [7:0]       sum_ff;
   logic [7:0]       sum_in;
   fdf_pkg::hdr_type hdr_ff;
   fdf_pkg::hdr_type hdr_in;
   logic [15:0]      idx;
   logic             near_end;
   logic [2:0]       info_lane;
   logic [2:0]       src_lane;
   logic [2:0]       dst_lane;
   logic [15:0]      full_length;

   assign idx         = count_ff + 16'd1;
   assign near_end    = ({1'b0, idx} + 17'd3) >= {1'b0, length_ff};
   assign info_lane   = idx[2:0] - 3'd4;
   assign src_lane    = idx[2:0] - 3'd2;
   assign dst_lane    = idx[2:0];
   assign full_length = {rx_byte, length_ff[7:0]};

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      length_in  = length_ff;
      sum_in     = sum_ff;
      hdr_in     = hdr_ff;
      push_valid = 1'b0;
      push_item.kind   = fdf_pkg::KIND_END;
      push_item.status = fdf_pkg::STAT_OK;
      push_item.data   = rx_byte;
      push_item.hdr    = hdr_ff;
      if (accept) begin
         if (phase_ff == PH_HUNT) begin
            if (rx_byte == fdf_pkg::START_BYTE) begin
               hdr_in    = '0;
               sum_in    = 8'd0;
               count_in  = 16'd0;
               length_in = 16'd0;
               phase_in  = PH_LEN_LO;
            end
         end else begin
            count_in = idx;
            if (phase_ff >= PH_CTRL && phase_ff <= PH_DATA) begin
               sum_in = sum_ff + rx_byte;
            end
            unique case (phase_ff)
               PH_LEN_LO: begin
                  length_in = {8'd0, rx_byte};
                  phase_in  = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  length_in = full_length;
                  if (full_length < fdf_pkg::FIXED_PLAIN) begin
                     push_valid       = 1'b1;
                     push_item.status = fdf_pkg::STAT_SHORT;
                     phase_in         = PH_HUNT;
                  end else begin
                     phase_in = PH_CTRL;
                  end
               end
               PH_CTRL: begin
                  hdr_in.ctrl = rx_byte;
                  phase_in    = PH_INFO;
               end
               PH_INFO: begin
                  for (int i = 0; i < 5; i++) begin
                     if (info_lane == 3'(i)) begin
                        hdr_in.info[8*i +: 8] = rx_byte;
                     end
                  end
                  if (idx == 16'd4 && rx_byte[2] && length_ff < fdf_pkg::FIXED_ADDR) begin
                     push_valid       = 1'b1;
                     push_item.status = fdf_pkg::STAT_SHORT;
                     phase_in         = PH_HUNT;
                  end else if (idx >= 16'd8) begin
                     phase_in = PH_SEQ;
                  end
               end
               PH_SEQ: begin
                  hdr_in.seq_num = rx_byte;
                  phase_in       = hdr_ff.info[2] ? PH_SRC : PH_AFN;
               end
               PH_SRC: begin
                  for (int i = 0; i < 6; i++) begin
                     if (src_lane == 3'(i)) begin
                        hdr_in.source[8*i +: 8] = rx_byte;
                     end
                  end
                  if (idx >= 16'd15) begin
                     phase_in = PH_DST;
                  end
               end
               PH_DST: begin
                  for (int i = 0; i < 6; i++) begin
                     if (dst_lane == 3'(i)) begin
                        hdr_in.dest[8*i +: 8] = rx_byte;
                     end
                  end
                  if (idx >= 16'd21) begin
                     phase_in = PH_AFN;
                  end
               end
               PH_AFN: begin
                  hdr_in.afn = rx_byte;
                  phase_in   = PH_FN_LO;
               end
               PH_FN_LO: begin
                  hdr_in.fn_id = {8'd0, rx_byte};
                  phase_in     = PH_FN_HI;
               end
               PH_FN_HI: begin
                  hdr_in.fn_id   = {rx_byte, hdr_ff.fn_id[7:0]};
                  push_valid     = 1'b1;
                  push_item.kind = fdf_pkg::KIND_HEADER;
                  push_item.hdr  = hdr_in;
                  phase_in       = near_end ? PH_CS : PH_DATA;
               end
               PH_DATA: begin
                  push_valid     = 1'b1;
                  push_item.kind = fdf_pkg::KIND_DATA;
                  if (near_end) begin
                     phase_in = PH_CS;
                  end
               end
               PH_CS: begin
                  sum_in   = sum_ff - rx_byte;
                  phase_in = PH_END;
               end
               PH_END: begin
                  push_valid = 1'b1;
                  if (rx_byte != fdf_pkg::END_BYTE) begin
                     push_item.status = fdf_pkg::STAT_END_BYTE;
                  end else if (sum_ff != 8'd0) begin
                     push_item.status = fdf_pkg::STAT_CHECKSUM;
                  end else begin
                     push_item.status = fdf_pkg::STAT_OK;
                  end
                  phase_in = PH_HUNT;
               end
               default: begin
                  phase_in = PH_HUNT;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         count_ff  <= 16'd0;
         length_ff <= 16'd0;
         sum_ff    <= 8'd0;
         hdr_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         sum_ff    <= sum_in;
         hdr_ff    <= hdr_in;
      end
   end

endmodule

// ===== design/fdf_back.sv =====
// output stage: takes items from the queue and presents result transactions
module fdf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  fdf_pkg::item_type pop_item,
   output logic              pop_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_item_kind,
   output logic [7:0]        rsp_control_byte,
   output logic [39:0]       rsp_info_field,
   output logic [7:0]        rsp_sequence_res,
   output logic [47:0]       rsp_source_addr,
   output logic [47:0]       rsp_dest_addr,
   output logic [7:0]        rsp_app_function,
   output logic [15:0]       rsp_unit_id,
   output logic [7:0]        rsp_payload_byte,
   output logic [1:0]        rsp_frame_status,
   output logic              rsp_last
);

   logic              valid_ff;
   logic              valid_in;
   fdf_pkg::item_type item_ff;
   fdf_pkg::item_type item_in;
   logic              is_header;
   logic              is_data;
   logic              is_end;

   assign pop_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = pop_ready ? pop_valid : valid_ff;
      item_in  = item_ff;
      if (pop_ready && pop_valid) begin
         item_in = pop_item;
         if (pop_item.kind != fdf_pkg::KIND_HEADER) begin
            item_in.hdr = '0;
         end
         if (pop_item.kind != fdf_pkg::KIND_DATA) begin
            item_in.data = 8'd0;
         end
         if (pop_item.kind != fdf_pkg::KIND_END) begin
            item_in.status = fdf_pkg::STAT_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign is_header = (item_ff.kind == fdf_pkg::KIND_HEADER);
   assign is_data   = (item_ff.kind == fdf_pkg::KIND_DATA);
   assign is_end    = (item_ff.kind == fdf_pkg::KIND_END);

   assign rsp_valid        = valid_ff;
   assign rsp_item_kind    = item_ff.kind;
   assign rsp_control_byte = item_ff.hdr.ctrl;
   assign rsp_info_field   = item_ff.hdr.info;
   assign rsp_sequence_res = item_ff.hdr.seq_num;
   assign rsp_source_addr  = item_ff.hdr.source;
   assign rsp_dest_addr    = item_ff.hdr.dest;
   assign rsp_app_function = item_ff.hdr.afn;
   assign rsp_unit_id      = item_ff.hdr.fn_id;
   assign rsp_payload_byte = is_data ? item_ff.data : 8'd0;
   assign rsp_frame_status = is_header ? fdf_pkg::STAT_OK : item_ff.status;
   assign rsp_last         = is_end;

endmodule

// ===== design/frame_deframer_376_2.sv =====
// top level of the 376.2 frame deframer
// Takes one received byte per transaction and decodes 376.2 frames: it hunts for
// the start byte, collects the header, emits a header transaction on the FN high
// byte, one transaction per data byte and an end status transaction on the end
// byte (checksum error or bad end byte), or earlier when the length is too short
// for the fixed part. A byte is accepted every cycle unless the queue is full; a
// two-entry queue plus the output register keep the input flowing while the
// result side stalls. The input stalls only when the queue is full.
`include "assert_macros.svh"

module frame_deframer_376_2 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_item_kind,
   output logic [7:0]  rsp_control_byte,
   output logic [39:0] rsp_info_field,
   output logic [7:0]  rsp_sequence_res,
   output logic [47:0] rsp_source_addr,
   output logic [47:0] rsp_dest_addr,
   output logic [7:0]  rsp_app_function,
   output logic [15:0] rsp_unit_id,
   output logic [7:0]  rsp_payload_byte,
   output logic [1:0]  rsp_frame_status,
   output logic        rsp_last
);

   logic              accept;
   logic              push_valid;
   fdf_pkg::item_type push_item;
   logic              q_full;
   logic              pop_ready;
   logic              pop_valid;
   fdf_pkg::item_type pop_item;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   fdf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   fdf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (q_full),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   fdf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_item         (pop_item),
      .pop_ready        (pop_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_control_byte (rsp_control_byte),
      .rsp_info_field   (rsp_info_field),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_source_addr  (rsp_source_addr),
      .rsp_dest_addr    (rsp_dest_addr),
      .rsp_app_function (rsp_app_function),
      .rsp_unit_id      (rsp_unit_id),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_status (rsp_frame_status),
      .rsp_last         (rsp_last)
   );

   // no item is produced unless a byte was taken, so a full queue never sees a push
   `ASSERT_IMPLIES(a_no_push_when_full, clock, reset, q_full, !push_valid)

   `ASSERT_IMPLIES(a_last_on_end, clock, reset, rsp_valid,
      rsp_last == (rsp_item_kind == fdf_pkg::KIND_END))

   `ASSERT_IMPLIES(a_hdr_zero_off_header, clock, reset,
      rsp_valid && rsp_item_kind != fdf_pkg::KIND_HEADER,
      rsp_control_byte == 8'd0 && rsp_unit_id == 16'd0 && rsp_info_field == 40'd0)

endmodule
